// File: src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mi3_pkg.sv
// types and constants of the 3x3 matrix inverse
package mi3_pkg;
    localparam int NStage   = 39;
    localparam int StDiv    = 6;
    localparam int DivSteps = 32;
    localparam int StOut    = 38;
    localparam int MagW     = 96;
    localparam int DetW     = 97;

    typedef logic signed [31:0] t_q16;
    typedef logic signed [63:0] t_q32;
    typedef logic [MagW-1:0]    t_mag;

    typedef struct packed {
        logic [31:0] q;
        logic        ovf;
        logic        neg;
    } t_div_res;

    typedef struct packed {
        logic               dneg;
        logic               sing;
        logic signed [47:0] det_value;
    } t_side;

    // operand indexes of the minors: adj = a[P1]*a[P2] - a[M1]*a[M2]
    localparam int unsigned IdxP1[9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int unsigned IdxP2[9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int unsigned IdxM1[9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int unsigned IdxM2[9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
endpackage

// File: src/mi3_adj.sv
// adjugate: products then differences, two stages
module mi3_adj (
    input  logic             i_clk,
    input  logic [1:0]       i_en,
    input  mi3_pkg::t_q16    i_a [9],
    output mi3_pkg::t_q32    o_adj [9],
    output mi3_pkg::t_q16    o_a [3]
);
    import mi3_pkg::*;

    t_q32 r_pp [9];
    t_q32 r_pm [9];
    t_q16 r_a0 [3];
    t_q32 r_adj [9];
    t_q16 r_a1 [3];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int k = 0; k < 9; k++) begin
                r_pp[k] <= 64'(i_a[IdxP1[k]]) * 64'(i_a[IdxP2[k]]);
                r_pm[k] <= 64'(i_a[IdxM1[k]]) * 64'(i_a[IdxM2[k]]);
            end
            for (int k = 0; k < 3; k++) r_a0[k] <= i_a[k];
        end
        if (i_en[1]) begin
            for (int k = 0; k < 9; k++) r_adj[k] <= r_pp[k] - r_pm[k];
            for (int k = 0; k < 3; k++) r_a1[k] <= r_a0[k];
        end
    end

    assign o_adj = r_adj;
    assign o_a   = r_a1;
endmodule

// File: src/mi3_det.sv
// determinant: split products, sum, magnitude and singular test
module mi3_det (
    input  logic             i_clk,
    input  logic [3:0]       i_en,
    input  mi3_pkg::t_q32    i_adj [9],
    input  mi3_pkg::t_q16    i_a [3],
    input  logic [30:0]      i_thr,
    output mi3_pkg::t_q32    o_adj [9],
    output mi3_pkg::t_mag    o_dmag,
    output mi3_pkg::t_side   o_side
);
    import mi3_pkg::*;

    logic signed [63:0]     r_ph [3];
    logic signed [64:0]     r_pl [3];
    logic signed [DetW-1:0] r_pr [3];
    logic signed [DetW-1:0] r_det;
    t_q32                   r_ad [4][9];
    t_mag                   r_dmag;
    t_side                  r_side;

    logic signed [DetW-1:0] w_neg;
    logic [DetW-1:0]        w_mag;
    logic signed [64:0]     w_sh;
    t_side                  n_side;

    always_comb begin
        w_neg = -r_det;
        w_mag = r_det[DetW-1] ? w_neg : r_det;
        w_sh  = 65'(r_det >>> 32);
        n_side.dneg = r_det[DetW-1];
        if (!w_sh[64] && (w_sh[63:47] != '0)) begin
            n_side.det_value = {1'b0, {47{1'b1}}};
        end else if (w_sh[64] && (w_sh[63:47] != '1)) begin
            n_side.det_value = {1'b1, 47'd0};
        end else begin
            n_side.det_value = w_sh[47:0];
        end
        n_side.sing = (w_mag == '0) || (w_mag < DetW'({i_thr, 32'd0}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_ph[k] <= 64'(i_a[k]) * 64'($signed(i_adj[3*k][63:32]));
                r_pl[k] <= 65'(i_a[k]) * 65'($signed({1'b0, i_adj[3*k][31:0]}));
            end
            r_ad[0] <= i_adj;
        end
        if (i_en[1]) begin
            for (int k = 0; k < 3; k++)
                r_pr[k] <= (DetW'(r_ph[k]) <<< 32) + DetW'(r_pl[k]);
            r_ad[1] <= r_ad[0];
        end
        if (i_en[2]) begin
            r_det   <= r_pr[0] + r_pr[1] + r_pr[2];
            r_ad[2] <= r_ad[1];
        end
        if (i_en[3]) begin
            r_dmag  <= w_mag[MagW-1:0];
            r_side  <= n_side;
            r_ad[3] <= r_ad[2];
        end
    end

    assign o_adj  = r_ad[3];
    assign o_dmag = r_dmag;
    assign o_side = r_side;
endmodule

// File: src/mi3_div.sv
// one lane of the pipelined restoring divider, one quotient bit per stage
module mi3_div (
    input  logic                               i_clk,
    input  logic [mi3_pkg::DivSteps-1:0]       i_en,
    input  mi3_pkg::t_q32                      i_adj,
    input  mi3_pkg::t_mag                      i_dm [mi3_pkg::DivSteps],
    output mi3_pkg::t_div_res                  o_res
);
    import mi3_pkg::*;

    t_mag        r_rem [DivSteps];
    logic [31:0] r_q   [DivSteps];
    logic        r_ovf [DivSteps];
    logic        r_neg [DivSteps];

    logic [63:0] w_am;
    logic        w_ovf;

    assign w_am  = i_adj[63] ? 64'(-i_adj) : i_adj;
    assign w_ovf = MagW'(w_am) >= i_dm[0];

    for (genvar j = 0; j < DivSteps; j++) begin : g_step
        t_mag          w_rin;
        logic [31:0]   w_qin;
        logic [MagW:0] w_t;
        logic [MagW:0] w_d;
        logic          w_ge;

        always_comb begin
            w_rin = (j == 0) ? MagW'(w_am) : r_rem[(j == 0) ? 0 : j-1];
            w_qin = (j == 0) ? 32'd0 : r_q[(j == 0) ? 0 : j-1];
            w_t   = {w_rin, 1'b0};
            w_d   = {1'b0, i_dm[j]};
            w_ge  = w_t >= w_d;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= w_ge ? MagW'(w_t - w_d) : w_t[MagW-1:0];
                r_q[j]   <= {w_qin[30:0], w_ge};
                r_ovf[j] <= (j == 0) ? w_ovf : r_ovf[(j == 0) ? 0 : j-1];
                r_neg[j] <= (j == 0) ? i_adj[63] : r_neg[(j == 0) ? 0 : j-1];
            end
        end
    end

    assign o_res = '{q: r_q[DivSteps-1], ovf: r_ovf[DivSteps-1], neg: r_neg[DivSteps-1]};
endmodule

// File: src/matrix3x3_inverse.sv
// top level of the 3x3 matrix inverse by adjugate
//  channel  dir  handshake                   contents
//  s_axis   in   tvalid/tready               tdata a11..a33, 32 bits each
//  m_axis   out  tvalid/tready               tdata r11..r33, det_value; tuser singular
//  cfg      in   i_cfg_wr_en                 singular_threshold, 31 bits
// 39 register stages: 2 adjugate, 4 determinant, 32 divider steps, 1 output
// one word accepted per cycle unless the pipeline is full and stalled; the divider steps set the depth
// a full stage holds when the next is full and stalled; bubbles close up under stall
// reset clears the stage valid bits and sets the threshold to 1
`include "assert_macros.svh"
module matrix3x3_inverse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [287:0]  i_s_axis_tdata,   // a11 a12 a13 a21 a22 a23 a31 a32 a33
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [335:0]  o_m_axis_tdata,   // r11 r12 r13 r21 r22 r23 r31 r32 r33 det_value
    output logic [0:0]    o_m_axis_tuser,   // singular
    input  logic          i_cfg_wr_en,
    input  logic [30:0]   i_cfg_wr_data
);
    import mi3_pkg::*;

    logic [NStage-1:0] r_v;
    logic [NStage:0]   w_rdy;
    logic [30:0]       r_thr;

    t_q16     w_a [9];
    t_q32     w_adj1 [9];
    t_q16     w_a1 [3];
    t_q32     w_adj5 [9];
    t_mag     w_dmag;
    t_side    w_side;
    t_mag     r_dm [DivSteps-1];
    t_side    r_sb [DivSteps];
    t_mag     w_dm [DivSteps];
    t_div_res w_res [9];
    logic [335:0] r_data;
    logic         r_sing;

    function automatic logic [31:0] f_sat(t_div_res res, logic dneg, logic sing);
        logic neg;
        neg = res.neg ^ dneg;
        if (sing) return 32'd0;
        if (neg) return (res.ovf || res.q > 32'h8000_0000) ? 32'h8000_0000 : -res.q;
        return (res.ovf || res.q[31]) ? 32'h7fff_ffff : res.q;
    endfunction

    always_comb begin
        w_rdy[NStage] = i_m_axis_tready;
        for (int k = NStage-1; k >= 0; k--) w_rdy[k] = !r_v[k] || w_rdy[k+1];
        for (int k = 0; k < 9; k++) w_a[k] = i_s_axis_tdata[32*k +: 32];
        w_dm[0] = w_dmag;
        for (int j = 1; j < DivSteps; j++) w_dm[j] = r_dm[j-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_thr <= 31'd1;
        end else begin
            for (int k = 0; k < NStage; k++)
                if (w_rdy[k]) r_v[k] <= (k == 0) ? i_s_axis_tvalid : r_v[(k == 0) ? 0 : k-1];
            if (i_cfg_wr_en) r_thr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DivSteps; j++) begin
            if (w_rdy[StDiv+j]) begin
                if (j < DivSteps-1) r_dm[(j < DivSteps-1) ? j : 0] <= w_dm[j];
                r_sb[j] <= (j == 0) ? w_side : r_sb[(j == 0) ? 0 : j-1];
            end
        end
        if (w_rdy[StOut]) begin
            for (int k = 0; k < 9; k++)
                r_data[32*k +: 32] <= f_sat(w_res[k], r_sb[DivSteps-1].dneg,
                                            r_sb[DivSteps-1].sing);
            r_data[335:288] <= r_sb[DivSteps-1].det_value;
            r_sing          <= r_sb[DivSteps-1].sing;
        end
    end

    mi3_adj u_adj (
        .i_clk (i_clk),
        .i_en  (w_rdy[1:0]),
        .i_a   (w_a),
        .o_adj (w_adj1),
        .o_a   (w_a1)
    );

    mi3_det u_det (
        .i_clk  (i_clk),
        .i_en   (w_rdy[5:2]),
        .i_adj  (w_adj1),
        .i_a    (w_a1),
        .i_thr  (r_thr),
        .o_adj  (w_adj5),
        .o_dmag (w_dmag),
        .o_side (w_side)
    );

    for (genvar k = 0; k < 9; k++) begin : g_lane
        mi3_div u_div (
            .i_clk (i_clk),
            .i_en  (w_rdy[StOut-1:StDiv]),
            .i_adj (w_adj5[k]),
            .i_dm  (w_dm),
            .o_res (w_res[k])
        );
    end

    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_v[StOut];
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tuser  = r_sing;

    `ASSERT_IMPL(a_sing_zero, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata[287:0] == '0, "singular word carries nonzero inverse")
    `ASSERT_IMPL(a_bubble_ready, !(&r_v), o_s_axis_tready, "input stalled while a stage is empty")
    `ASSERT_NEXT(a_cfg_write, i_cfg_wr_en, r_thr == $past(i_cfg_wr_data), "threshold write lost")
endmodule

// File: tb/sv/tb_top.sv
// testbench of the 3x3 matrix inverse: predicts each inverse and checks every output word
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_axis_tvalid;
    logic          o_s_axis_tready;
    logic [287:0]  i_s_axis_tdata;   // a11 a12 a13 a21 a22 a23 a31 a32 a33
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready;
    logic [335:0]  o_m_axis_tdata;   // r11 .. r33 det_value
    logic [0:0]    o_m_axis_tuser;   // singular
    logic          i_cfg_wr_en;
    logic [30:0]   i_cfg_wr_data;

    typedef struct packed {
        logic         singular;
        logic [335:0] data;
    } t_inverse;

    t_inverse  inverse_q[$];
    logic [30:0] threshold;
    int        n_errors;
    int        idle_pct;
    int        hold_cycles;

    matrix3x3_inverse u_top (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic t_inverse invert_matrix(input logic [287:0] m);
        logic signed [31:0]  a[9];
        logic signed [63:0]  adj[9];
        logic signed [127:0] det;
        logic [127:0]        dmag;
        logic [127:0]        num;
        logic [127:0]        q;
        logic [127:0]        am;
        logic signed [127:0] dv;
        logic                dneg;
        logic                qneg;
        t_inverse            res;
        for (int k = 0; k < 9; k++) a[k] = m[32*k +: 32];
        adj[0] = 64'(a[4]) * a[8] - 64'(a[5]) * a[7];
        adj[1] = 64'(a[2]) * a[7] - 64'(a[1]) * a[8];
        adj[2] = 64'(a[1]) * a[5] - 64'(a[2]) * a[4];
        adj[3] = 64'(a[5]) * a[6] - 64'(a[3]) * a[8];
        adj[4] = 64'(a[0]) * a[8] - 64'(a[2]) * a[6];
        adj[5] = 64'(a[2]) * a[3] - 64'(a[0]) * a[5];
        adj[6] = 64'(a[3]) * a[7] - 64'(a[4]) * a[6];
        adj[7] = 64'(a[1]) * a[6] - 64'(a[0]) * a[7];
        adj[8] = 64'(a[0]) * a[4] - 64'(a[1]) * a[3];
        det = 128'(a[0]) * 128'(adj[0]) + 128'(a[1]) * 128'(adj[3])
            + 128'(a[2]) * 128'(adj[6]);
        dneg = det[127];
        dmag = dneg ? -det : det;
        dv = det >>> 32;
        if (dv > 128'sh7FFF_FFFF_FFFF) res.data[335:288] = 48'h7FFF_FFFF_FFFF;
        else if (dv < -128'sh8000_0000_0000) res.data[335:288] = 48'h8000_0000_0000;
        else res.data[335:288] = dv[47:0];
        res.singular = (dmag == 0) || (dmag < ({97'd0, threshold} << 32));
        for (int k = 0; k < 9; k++) begin
            if (res.singular) begin
                res.data[32*k +: 32] = '0;
            end else begin
                am = adj[k][63] ? -128'(adj[k]) : 128'(adj[k]);
                num = am << 32;
                q = num / dmag;
                qneg = adj[k][63] != dneg;
                if (qneg) res.data[32*k +: 32] = (q > 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
                else res.data[32*k +: 32] = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
            end
        end
        return res;
    endfunction

    task automatic report(input string what, input logic [335:0] got, input logic [335:0] exp);
        $display("mismatch %s: got %h exp %h", what, got, exp);
        n_errors++;
    endtask

    task automatic send_matrix(input logic [287:0] m);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= m;
        inverse_q.push_back(invert_matrix(m));
        do @(posedge i_clk); while (!o_s_axis_tready);
        if ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [30:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        threshold     <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(5))
            0: rand_entry = $urandom();
            1: rand_entry = 32'h8000_0000 | $urandom_range(3);
            2: rand_entry = 32'h7FFF_FFFF - $urandom_range(3);
            3: rand_entry = $urandom_range(8) << 16;
            4: rand_entry = -($urandom_range(8) << 16);
            default: rand_entry = 32'($signed($urandom_range(200000)) - 100000);
        endcase
    endfunction

    function automatic logic [287:0] rand_matrix();
        logic [287:0] m;
        for (int k = 0; k < 9; k++) m[32*k +: 32] = rand_entry();
        if ($urandom_range(9) == 0) m[191:96] = m[95:0];
        return m;
    endfunction

    function automatic logic [287:0] diag(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z);
        return {x, 96'd0, y, 96'd0, z};
    endfunction

    task automatic test_directed();
        send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_matrix(diag(32'hFFFF_0000, 32'h0002_0000, 32'h0004_0000));
        send_matrix(diag(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000));
        send_matrix('0);
        send_matrix('1);
        send_matrix({9{32'h8000_0000}});
        send_matrix({9{32'h7FFF_FFFF}});
        send_matrix(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'hFFFF_FF00));
        send_matrix({32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000,
                     32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0002_0000,
                     32'h0001_0000});
        send_matrix({32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'hEDCB_A987,
                     32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC,
                     32'h0000_FFFF});
        drain();
    endtask

    task automatic test_thresholds();
        logic [30:0] thr[4] = '{31'd0, 31'h7FFF_FFFF, 31'h0001_0000, 31'd1};
        foreach (thr[i]) begin
            set_threshold(thr[i]);
            send_matrix('0);
            send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000));
            send_matrix(diag(32'h0000_FFFF, 32'h0001_0000, 32'h0001_0000));
            for (int n = 0; n < 20; n++) send_matrix(rand_matrix());
            drain();
        end
    endtask

    task automatic test_random();
        for (int n = 0; n < 885; n++) begin
            idle_pct = (n >= 300 && n < 450) ? 0 : 31;
            if (n == 500) begin
                drain();
                set_threshold(31'($urandom()));
            end
            send_matrix(rand_matrix());
            if (n == 700 || n == 350) begin
                drain();
                set_threshold(31'($urandom_range(1 << 20)));
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_cycles = 200;
        for (int n = 0; n < 60; n++) send_matrix(rand_matrix());
        drain();
    endtask

    // receiver: random stalls, or a long counted hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles     <= hold_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_inverse exp;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (inverse_q.size() == 0) begin
                report("unexpected word", o_m_axis_tdata, '0);
            end else begin
                exp = inverse_q.pop_front();
                for (int k = 0; k < 9; k++)
                    if (o_m_axis_tdata[32*k +: 32] !== exp.data[32*k +: 32])
                        report($sformatf("r%0d%0d", k / 3 + 1, k % 3 + 1),
                               o_m_axis_tdata[32*k +: 32], exp.data[32*k +: 32]);
                if (o_m_axis_tdata[335:288] !== exp.data[335:288])
                    report("det_value", o_m_axis_tdata[335:288], exp.data[335:288]);
                if (o_m_axis_tuser[0] !== exp.singular)
                    report("singular", o_m_axis_tuser, exp.singular);
            end
        end
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        n_errors        = 0;
        idle_pct        = 31;
        hold_cycles     = 0;
        threshold       = 31'd1;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_thresholds();
        test_backpressure();
        test_random();
        if (inverse_q.size() != 0) n_errors++;
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/mi3_pkg.sv
src/mi3_adj.sv
src/mi3_det.sv
src/mi3_div.sv
src/matrix3x3_inverse.sv
tb/sv/tb_top.sv
